>>> hdl/sfla_pkg.sv
// Shared types and constants of the sorted free-list allocator.
`timescale 1ns / 1ps
package sfla_pkg;

   // Fixed widths of the request and response address and size ports.
   localparam int ADDR_PORT_W = 32;
   localparam int SIZE_PORT_W = 32;

   // Request kinds carried on req_type.
   typedef enum logic {
      REQ_ALLOC = 1'b0,
      REQ_FREE  = 1'b1
   } req_kind_type;

   // Response status codes.
   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_NOFIT = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // Operation applied to every cell of the table chain at once.
   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_REMOVE = 2'd2
   } cell_op_type;

   // Status flags that each cell reports to its neighbours and the top level.
   typedef struct packed {
      logic valid;
      logic le;
      logic fit;
   } cell_flags_type;

endpackage

>>> hdl/sorted_free_list_allocator_top.sv
// Top level of the sorted free-list allocator: cell chain, selector and control.
//
// Usage. A request is taken at a rising edge with start high and busy low.
// req_type selects allocate or free; req_block_size is the wanted size on
// allocate and the freed size on free; req_free_address is the freed block's
// start address. Each request gives exactly one response, shown on
// rsp_granted_address and rsp_status for one cycle with rsp_valid high; the
// receiver cannot hold it off, so nothing ever waits at the output.
// A free keeps busy high while the cells compare their addresses with the new
// one in parallel and shift right by one place behind it. An allocate keeps
// busy high while each level of the registered selection tree is reduced in
// turn, and then while the cells behind the chosen entry shift left by one
// place. The response strobe is registered and shows in the first cycle with
// busy low, and a new request may be started in that same cycle.
// The mode register is written on the csr_ channel, which is always ready;
// the user must write it only while no request is in flight, since the block
// itself does not enforce this. Synchronous reset empties the table, selects
// first fit and drops any request in flight.
`timescale 1ns / 1ps
module sorted_free_list_allocator_top
   import sfla_pkg::*;
#(
   parameter int TABLE_ENTRIES = 16,
   parameter int ADDR_WIDTH    = 32,
   parameter int SIZE_WIDTH    = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic                   req_type,
   input  logic [SIZE_PORT_W-1:0] req_block_size,
   input  logic [ADDR_PORT_W-1:0] req_free_address,
   output logic                   rsp_valid,
   output logic [ADDR_PORT_W-1:0] rsp_granted_address,
   output logic [1:0]             rsp_status,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_fit_mode
);

   localparam int IDX_W  = $clog2(TABLE_ENTRIES);
   localparam int ROUNDS = $clog2(TABLE_ENTRIES);
   localparam int RND_W  = $clog2(ROUNDS) + 1;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_FREE   = 4'b0010,
      S_REDUCE = 4'b0100,
      S_REMOVE = 4'b1000
   } state_type;

   state_type              state_ff, state_in;
   logic [RND_W-1:0]       round_ff, round_in;
   logic                   fit_mode_ff, fit_mode_in;
   logic [ADDR_WIDTH-1:0]  req_addr_ff, req_addr_in;
   logic [SIZE_WIDTH-1:0]  req_size_ff, req_size_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [ADDR_PORT_W-1:0] rsp_addr_ff, rsp_addr_in;
   status_type             rsp_status_ff, rsp_status_in;

   logic                   accept;
   logic                   table_full;
   logic [SIZE_WIDTH-1:0]  want;
   cell_op_type            cell_op;
   logic                   sel_load;
   logic                   sel_step;
   logic                   win_fit;
   logic [ADDR_WIDTH-1:0]  win_addr;
   logic [IDX_W-1:0]       win_idx;

   cell_flags_type         cell_flags [TABLE_ENTRIES];
   logic [ADDR_WIDTH-1:0]  cell_addr  [TABLE_ENTRIES];
   logic [SIZE_WIDTH-1:0]  cell_size  [TABLE_ENTRIES];
   logic                   cell_fit   [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] valid_vec;

   assign accept     = start && !busy;
   assign busy       = (state_ff != S_IDLE);
   assign csr_ready  = 1'b1;
   assign want       = SIZE_WIDTH'(req_block_size);
   assign table_full = cell_flags[TABLE_ENTRIES-1].valid;
   assign sel_load   = accept && (req_type == REQ_ALLOC);
   assign sel_step   = (state_ff == S_REDUCE);

   // The chain of table cells, each wired to its two neighbours.
   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      cell_flags_type        l_flags, r_flags;
      logic [ADDR_WIDTH-1:0] l_addr, r_addr;
      logic [SIZE_WIDTH-1:0] l_size, r_size;

      // The head cell sees a left neighbour that always lies below the new
      // address; the tail cell sees an empty right neighbour.
      if (i == 0) begin : g_head
         assign l_flags = '{valid: 1'b0, le: 1'b1, fit: 1'b0};
         assign l_addr  = '0;
         assign l_size  = '0;
      end else begin : g_left
         assign l_flags = cell_flags[i-1];
         assign l_addr  = cell_addr[i-1];
         assign l_size  = cell_size[i-1];
      end

      if (i == TABLE_ENTRIES - 1) begin : g_tail
         assign r_flags = '0;
         assign r_addr  = '0;
         assign r_size  = '0;
      end else begin : g_right
         assign r_flags = cell_flags[i+1];
         assign r_addr  = cell_addr[i+1];
         assign r_size  = cell_size[i+1];
      end

      sfla_cell #(
         .TABLE_ENTRIES (TABLE_ENTRIES),
         .ADDR_WIDTH    (ADDR_WIDTH),
         .SIZE_WIDTH    (SIZE_WIDTH),
         .INDEX         (i)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .op          (cell_op),
         .new_addr    (req_addr_ff),
         .new_size    (req_size_ff),
         .want        (want),
         .rm_idx      (win_idx),
         .left_flags  (l_flags),
         .left_addr   (l_addr),
         .left_size   (l_size),
         .right_flags (r_flags),
         .right_addr  (r_addr),
         .right_size  (r_size),
         .flags       (cell_flags[i]),
         .addr        (cell_addr[i]),
         .size        (cell_size[i])
      );

      assign cell_fit[i]  = cell_flags[i].fit;
      assign valid_vec[i] = cell_flags[i].valid;
   end

   // Selection tree over the fit flags of all cells.
   sfla_select #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .ADDR_WIDTH    (ADDR_WIDTH),
      .SIZE_WIDTH    (SIZE_WIDTH)
   ) u_select (
      .clock     (clock),
      .load      (sel_load),
      .step      (sel_step),
      .fit_mode  (fit_mode_ff),
      .leaf_fit  (cell_fit),
      .leaf_size (cell_size),
      .leaf_addr (cell_addr),
      .win_fit   (win_fit),
      .win_addr  (win_addr),
      .win_idx   (win_idx)
   );

   // Operation for the cell chain in the current cycle.
   always_comb begin
      cell_op = CELL_HOLD;
      if ((state_ff == S_FREE) && !table_full) begin
         cell_op = CELL_INSERT;
      end else if ((state_ff == S_REMOVE) && win_fit) begin
         cell_op = CELL_REMOVE;
      end
   end

   // Sequencer, request capture and response formation.
   always_comb begin
      state_in      = state_ff;
      round_in      = round_ff;
      req_addr_in   = req_addr_ff;
      req_size_in   = req_size_ff;
      rsp_valid_in  = 1'b0;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      fit_mode_in   = fit_mode_ff;

      if (csr_valid && csr_ready) begin
         fit_mode_in = csr_fit_mode;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_addr_in = ADDR_WIDTH'(req_free_address);
               req_size_in = want;
               round_in    = RND_W'(ROUNDS - 1);
               state_in    = (req_type == REQ_FREE) ? S_FREE : S_REDUCE;
            end
         end
         S_FREE: begin
            rsp_valid_in  = 1'b1;
            rsp_addr_in   = '0;
            rsp_status_in = table_full ? ST_FULL : ST_DONE;
            state_in      = S_IDLE;
         end
         S_REDUCE: begin
            if (round_ff == '0) begin
               state_in = S_REMOVE;
            end else begin
               round_in = round_ff - RND_W'(1);
            end
         end
         S_REMOVE: begin
            rsp_valid_in  = 1'b1;
            rsp_addr_in   = win_fit ? ADDR_PORT_W'(win_addr) : '0;
            rsp_status_in = win_fit ? ST_DONE : ST_NOFIT;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         fit_mode_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         fit_mode_ff  <= fit_mode_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      round_ff      <= round_in;
      req_addr_ff   <= req_addr_in;
      req_size_ff   <= req_size_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_granted_address = rsp_addr_ff;
   assign rsp_status          = rsp_status_ff;

   // A response strobe comes only out of a free or a removal cycle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(state_ff) == S_FREE || $past(state_ff) == S_REMOVE))
      else $error("response strobe without a finishing cycle");

   // Occupied cells always form an unbroken run from the head of the chain.
   assert property (@(posedge clock) disable iff (reset)
      ((valid_vec & (valid_vec + TABLE_ENTRIES'(1))) == '0))
      else $error("gap in the occupied cells");

   // A table-full response is given only while the last cell is occupied.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == ST_FULL)) |-> valid_vec[TABLE_ENTRIES-1])
      else $error("table full reported with room left");

   // Any response other than done carries a zero address.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != ST_DONE)) |-> (rsp_granted_address == '0))
      else $error("address returned on a failed request");

   // A taken request always makes the block busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("request taken without going busy");

endmodule

>>> hdl/sfla_cell.sv
// One cell of the free table chain: holds one address and size entry.
`timescale 1ns / 1ps
module sfla_cell
   import sfla_pkg::*;
#(
   parameter int TABLE_ENTRIES = 16,
   parameter int ADDR_WIDTH    = 32,
   parameter int SIZE_WIDTH    = 32,
   parameter int INDEX         = 0
) (
   input  logic                             clock,
   input  logic                             reset,
   input  cell_op_type                      op,
   input  logic [ADDR_WIDTH-1:0]            new_addr,
   input  logic [SIZE_WIDTH-1:0]            new_size,
   input  logic [SIZE_WIDTH-1:0]            want,
   input  logic [$clog2(TABLE_ENTRIES)-1:0] rm_idx,
   input  cell_flags_type                   left_flags,
   input  logic [ADDR_WIDTH-1:0]            left_addr,
   input  logic [SIZE_WIDTH-1:0]            left_size,
   input  cell_flags_type                   right_flags,
   input  logic [ADDR_WIDTH-1:0]            right_addr,
   input  logic [SIZE_WIDTH-1:0]            right_size,
   output cell_flags_type                   flags,
   output logic [ADDR_WIDTH-1:0]            addr,
   output logic [SIZE_WIDTH-1:0]            size
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic                  valid_ff, valid_in;
   logic [ADDR_WIDTH-1:0] addr_ff, addr_in;
   logic [SIZE_WIDTH-1:0] size_ff, size_in;

   // Local comparisons against the request in hand.
   assign flags.valid = valid_ff;
   assign flags.le    = valid_ff && (addr_ff <= new_addr);
   assign flags.fit   = valid_ff && (size_ff >= want);
   assign addr        = addr_ff;
   assign size        = size_ff;

   // Next entry: keep, take the new entry, or take a neighbour's entry.
   always_comb begin
      valid_in = valid_ff;
      addr_in  = addr_ff;
      size_in  = size_ff;
      case (op)
         CELL_INSERT: begin
            if (!flags.le) begin
               if (left_flags.le) begin
                  valid_in = 1'b1;
                  addr_in  = new_addr;
                  size_in  = new_size;
               end else begin
                  valid_in = left_flags.valid;
                  addr_in  = left_addr;
                  size_in  = left_size;
               end
            end
         end
         CELL_REMOVE: begin
            if (MY_IDX >= rm_idx) begin
               valid_in = right_flags.valid;
               addr_in  = right_addr;
               size_in  = right_size;
            end
         end
         default: begin
         end
      endcase
   end

   // Only the valid bit is control state; the entry payload needs no reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      size_ff <= size_in;
   end

endmodule

>>> hdl/sfla_select.sv
// Registered pairwise tree that picks the entry to hand out on allocate.
`timescale 1ns / 1ps
module sfla_select
   import sfla_pkg::*;
#(
   parameter int TABLE_ENTRIES = 16,
   parameter int ADDR_WIDTH    = 32,
   parameter int SIZE_WIDTH    = 32
) (
   input  logic                             clock,
   input  logic                             load,
   input  logic                             step,
   input  logic                             fit_mode,
   input  logic                             leaf_fit  [TABLE_ENTRIES],
   input  logic [SIZE_WIDTH-1:0]            leaf_size [TABLE_ENTRIES],
   input  logic [ADDR_WIDTH-1:0]            leaf_addr [TABLE_ENTRIES],
   output logic                             win_fit,
   output logic [ADDR_WIDTH-1:0]            win_addr,
   output logic [$clog2(TABLE_ENTRIES)-1:0] win_idx
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int HALF  = (TABLE_ENTRIES + 1) / 2;

   typedef struct packed {
      logic                  fit;
      logic [SIZE_WIDTH-1:0] size;
      logic [ADDR_WIDTH-1:0] addr;
      logic [IDX_W-1:0]      idx;
   } cand_type;

   cand_type cand_ff [TABLE_ENTRIES];
   cand_type cand_in [TABLE_ENTRIES];
   cand_type pair_win [TABLE_ENTRIES];

   // The left candidate always holds the lower table index. First fit keeps
   // the left one whenever it fits; largest fit takes the right one only when
   // it is strictly larger, so the lower address wins a tie.
   function automatic cand_type pick(input cand_type lo, input cand_type hi,
                                     input logic mode);
      cand_type res;
      if (!mode) begin
         res = lo.fit ? lo : hi;
      end else if (hi.fit && (!lo.fit || (hi.size > lo.size))) begin
         res = hi;
      end else begin
         res = lo;
      end
      return res;
   endfunction

   // One level of the tree: slot i takes the winner of slots 2i and 2i+1.
   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_pair
      if ((i < HALF) && (2 * i + 1 < TABLE_ENTRIES)) begin : g_two
         assign pair_win[i] = pick(cand_ff[2*i], cand_ff[2*i+1], fit_mode);
      end else if (i < HALF) begin : g_one
         assign pair_win[i] = cand_ff[2*i];
      end else begin : g_none
         assign pair_win[i] = '0;
      end
   end

   // Load the leaves from the cells, or reduce by one level.
   always_comb begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (load) begin
            cand_in[i].fit  = leaf_fit[i];
            cand_in[i].size = leaf_size[i];
            cand_in[i].addr = leaf_addr[i];
            cand_in[i].idx  = IDX_W'(i);
         end else if (step) begin
            cand_in[i] = pair_win[i];
         end else begin
            cand_in[i] = cand_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      cand_ff <= cand_in;
   end

   assign win_fit  = cand_ff[0].fit;
   assign win_addr = cand_ff[0].addr;
   assign win_idx  = cand_ff[0].idx;

endmodule
